// ----- sv/ffaa_pkg.sv -----
package ffaa_pkg;

    localparam int ARENA_WORDS = 1024;
    localparam int HDR_WORDS   = 3;
    localparam int END_POS     = ARENA_WORDS - HDR_WORDS;
    localparam int POS_W       = $clog2(ARENA_WORDS);
    localparam int WORD_W      = 10;

    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [POS_W:0]    ext_t;
    typedef logic [POS_W+1:0]  wide_t;
    typedef logic [WORD_W-1:0] word_t;

    localparam logic FUNC_ALLOC  = 1'b0;
    localparam logic FUNC_FREE   = 1'b1;
    localparam logic ST_OK       = 1'b0;
    localparam logic ST_NO_SPACE = 1'b1;

    typedef enum logic [3:0] {
        S_A0,
        S_A1,
        S_A2,
        S_A3,
        S_FAIL,
        S_W0,
        S_W1,
        S_OK,
        S_F0,
        S_F1,
        S_F2,
        S_ZERO
    } step_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_NEW,
        WR_LINK,
        WR_FREE
    } wr_sel_t;

    typedef enum logic [2:0] {
        C_NONE,
        C_BAD_JUMP,
        C_FIT,
        C_NOT_END,
        C_HANDLE_LOW,
        C_FREE_BAD
    } cond_t;

    typedef enum logic [1:0] {
        FIN_NONE,
        FIN_OK,
        FIN_FAIL,
        FIN_ZERO
    } fin_t;

    typedef struct packed {
        logic    ld_link;
        logic    ld_free;
        logic    adv;
        wr_sel_t wr_sel;
        cond_t   cond;
        step_t   target;
        fin_t    fin;
    } uword_t;

    function automatic uword_t ucode(input step_t step);
        uword_t w;
        w = '0;
        unique case (step)
            S_A0:
            begin
                w.cond = C_NONE;
            end
            S_A1:
            begin
                w.ld_link = 1'b1;
                w.cond    = C_BAD_JUMP;
                w.target  = S_FAIL;
            end
            S_A2:
            begin
                w.cond   = C_FIT;
                w.target = S_W0;
            end
            S_A3:
            begin
                w.adv    = 1'b1;
                w.cond   = C_NOT_END;
                w.target = S_A0;
            end
            S_FAIL:
            begin
                w.fin = FIN_FAIL;
            end
            S_W0:
            begin
                w.wr_sel = WR_NEW;
            end
            S_W1:
            begin
                w.wr_sel = WR_LINK;
            end
            S_OK:
            begin
                w.fin = FIN_OK;
            end
            S_F0:
            begin
                w.cond   = C_HANDLE_LOW;
                w.target = S_ZERO;
            end
            S_F1:
            begin
                w.ld_free = 1'b1;
                w.cond    = C_FREE_BAD;
                w.target  = S_ZERO;
            end
            S_F2:
            begin
                w.wr_sel = WR_FREE;
            end
            S_ZERO:
            begin
                w.fin = FIN_ZERO;
            end
            default:
            begin
                w.fin = FIN_ZERO;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- sv/ffaa_if.sv -----
interface ffaa_req_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [ffaa_pkg::WORD_W-1:0] req_words;
    logic [ffaa_pkg::WORD_W-1:0] handle;

    modport source (output valid, func, req_words, handle, input ready);
    modport sink (input valid, func, req_words, handle, output ready);
endinterface

interface ffaa_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        status;
    logic [ffaa_pkg::WORD_W-1:0] payload_offset;

    modport source (output valid, status, payload_offset, input ready);
    modport sink (input valid, status, payload_offset, output ready);
endinterface

// ----- sv/first_fit_arena_allocator_unit.sv -----
// First-fit arena allocator over a 1024-word arena kept as a chain of blocks with three-word
// headers (size, forward jump, backward jump) held in three header RAMs. After reset the unit
// runs a clearing pass over all ARENA_WORDS (1024) header addresses that lays down the anchor
// and suffix blocks; req.ready stays low until it ends. An allocate beat walks the chain from
// the anchor until a gap fits or the walk reaches the suffix; a free beat checks the handle
// and its jumps, then relinks the neighbours. The pace is set by the microcode loop around
// the single registered read port of the header RAMs. A new beat is taken while the previous
// result still waits in the output register.
module first_fit_arena_allocator_unit (
    input logic         clk,
    input logic         rst_n,
    ffaa_req_if.sink    req,
    ffaa_rsp_if.source  rsp
);

    localparam ffaa_pkg::pos_t LAST_ADDR = ffaa_pkg::POS_W'(ffaa_pkg::ARENA_WORDS - 1);
    localparam ffaa_pkg::pos_t END_ADDR  = ffaa_pkg::POS_W'(ffaa_pkg::END_POS);

    logic               busy_reg, busy_next;
    ffaa_pkg::step_t    step_reg, step_next;
    logic               clr_active_reg, clr_active_next;
    ffaa_pkg::pos_t     clr_addr_reg, clr_addr_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_status_reg, out_status_next;
    ffaa_pkg::word_t    out_offset_reg, out_offset_next;
    ffaa_pkg::pos_t     pos_reg, pos_next;
    ffaa_pkg::pos_t     prv_reg, prv_next;
    ffaa_pkg::ext_t     nxt_reg, nxt_next;
    ffaa_pkg::wide_t    end_reg, end_next;
    ffaa_pkg::word_t    req_reg, req_next;
    ffaa_pkg::ext_t     req3_reg, req3_next;
    logic               hlow_reg, hlow_next;

    ffaa_pkg::uword_t   uw;
    ffaa_pkg::word_t    size_rd, next_rd, prev_rd;
    ffaa_pkg::ext_t     sum_nxt;
    ffaa_pkg::wide_t    end_calc;
    ffaa_pkg::wide_t    gap;
    logic               bad_jump, fit, not_end, free_bad;
    logic               cond_true, slot_free, accept;

    logic               size_we, next_we, prev_we;
    ffaa_pkg::pos_t     size_waddr, next_waddr, prev_waddr;
    ffaa_pkg::word_t    size_wdata, next_wdata, prev_wdata;

    ffaa_ram #(.DEPTH(ffaa_pkg::ARENA_WORDS), .WIDTH(ffaa_pkg::WORD_W)) u_size_ram (
        .clk   (clk),
        .we    (size_we),
        .waddr (size_waddr),
        .wdata (size_wdata),
        .raddr (pos_reg),
        .rdata (size_rd)
    );

    ffaa_ram #(.DEPTH(ffaa_pkg::ARENA_WORDS), .WIDTH(ffaa_pkg::WORD_W)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (pos_reg),
        .rdata (next_rd)
    );

    ffaa_ram #(.DEPTH(ffaa_pkg::ARENA_WORDS), .WIDTH(ffaa_pkg::WORD_W)) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (pos_reg),
        .rdata (prev_rd)
    );

    assign uw        = ffaa_pkg::ucode(step_reg);
    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = !busy_reg && !clr_active_reg;
    assign accept    = req.valid && req.ready;

    assign sum_nxt  = ffaa_pkg::ext_t'(pos_reg) + ffaa_pkg::ext_t'(next_rd);
    assign end_calc = ffaa_pkg::wide_t'(pos_reg) + ffaa_pkg::wide_t'(ffaa_pkg::HDR_WORDS)
                    + ffaa_pkg::wide_t'(size_rd);
    assign gap      = ffaa_pkg::wide_t'(nxt_reg) - end_reg;
    assign bad_jump = (next_rd == '0)
                   || (sum_nxt >= ffaa_pkg::ext_t'(ffaa_pkg::ARENA_WORDS));
    assign fit      = (ffaa_pkg::wide_t'(nxt_reg) >= end_reg)
                   && (gap >= ffaa_pkg::wide_t'(req3_reg));
    assign not_end  = nxt_reg < ffaa_pkg::ext_t'(ffaa_pkg::END_POS);
    assign free_bad = (ffaa_pkg::ext_t'(prev_rd) > ffaa_pkg::ext_t'(pos_reg))
                   || (sum_nxt >= ffaa_pkg::ext_t'(ffaa_pkg::ARENA_WORDS));

    always_comb
    begin
        unique case (uw.cond)
            ffaa_pkg::C_NONE:       cond_true = 1'b0;
            ffaa_pkg::C_BAD_JUMP:   cond_true = bad_jump;
            ffaa_pkg::C_FIT:        cond_true = fit;
            ffaa_pkg::C_NOT_END:    cond_true = not_end;
            ffaa_pkg::C_HANDLE_LOW: cond_true = hlow_reg;
            ffaa_pkg::C_FREE_BAD:   cond_true = free_bad;
            default:                cond_true = 1'b0;
        endcase
    end

    // header RAM write port: clearing pass first, then the microcode
    always_comb
    begin
        size_we    = 1'b0;
        next_we    = 1'b0;
        prev_we    = 1'b0;
        size_waddr = end_reg[ffaa_pkg::POS_W-1:0];
        next_waddr = pos_reg;
        prev_waddr = nxt_reg[ffaa_pkg::POS_W-1:0];
        size_wdata = req_reg;
        next_wdata = ffaa_pkg::WORD_W'(end_reg - ffaa_pkg::wide_t'(pos_reg));
        prev_wdata = ffaa_pkg::WORD_W'(gap);
        if (clr_active_reg)
        begin
            size_we    = (clr_addr_reg == '0) || (clr_addr_reg == END_ADDR);
            next_we    = 1'b1;
            prev_we    = 1'b1;
            size_waddr = clr_addr_reg;
            next_waddr = clr_addr_reg;
            prev_waddr = clr_addr_reg;
            size_wdata = '0;
            next_wdata = (clr_addr_reg == '0) ? ffaa_pkg::WORD_W'(ffaa_pkg::END_POS) : '0;
            prev_wdata = (clr_addr_reg == END_ADDR) ?
                         ffaa_pkg::WORD_W'(ffaa_pkg::END_POS) : '0;
        end
        else if (busy_reg)
        begin
            unique case (uw.wr_sel)
                ffaa_pkg::WR_NONE:
                begin
                    size_we = 1'b0;
                end
                ffaa_pkg::WR_NEW:
                begin
                    size_we    = 1'b1;
                    next_we    = 1'b1;
                    prev_we    = 1'b1;
                    next_waddr = end_reg[ffaa_pkg::POS_W-1:0];
                    prev_waddr = end_reg[ffaa_pkg::POS_W-1:0];
                    next_wdata = ffaa_pkg::WORD_W'(gap);
                    prev_wdata = ffaa_pkg::WORD_W'(end_reg - ffaa_pkg::wide_t'(pos_reg));
                end
                ffaa_pkg::WR_LINK:
                begin
                    next_we = 1'b1;
                    prev_we = 1'b1;
                end
                ffaa_pkg::WR_FREE:
                begin
                    next_we    = 1'b1;
                    prev_we    = 1'b1;
                    next_waddr = prv_reg;
                    next_wdata = ffaa_pkg::WORD_W'(nxt_reg - ffaa_pkg::ext_t'(prv_reg));
                    prev_wdata = ffaa_pkg::WORD_W'(nxt_reg - ffaa_pkg::ext_t'(prv_reg));
                end
                default:
                begin
                    size_we = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        busy_next       = busy_reg;
        step_next       = step_reg;
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_offset_next = out_offset_reg;
        pos_next        = pos_reg;
        prv_next        = prv_reg;
        nxt_next        = nxt_reg;
        end_next        = end_reg;
        req_next        = req_reg;
        req3_next       = req3_reg;
        hlow_next       = hlow_reg;

        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + ffaa_pkg::pos_t'(1);
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_active_next = 1'b0;
            end
        end

        if (accept)
        begin
            busy_next = 1'b1;
            req_next  = req.req_words;
            req3_next = ffaa_pkg::ext_t'(req.req_words)
                      + ffaa_pkg::ext_t'(ffaa_pkg::HDR_WORDS);
            hlow_next = req.handle < ffaa_pkg::WORD_W'(ffaa_pkg::HDR_WORDS);
            if (req.func == ffaa_pkg::FUNC_FREE)
            begin
                step_next = ffaa_pkg::S_F0;
                pos_next  = ffaa_pkg::POS_W'(req.handle)
                          - ffaa_pkg::POS_W'(ffaa_pkg::HDR_WORDS);
            end
            else
            begin
                step_next = ffaa_pkg::S_A0;
                pos_next  = '0;
            end
        end
        else if (busy_reg)
        begin
            if (uw.ld_link)
            begin
                nxt_next = sum_nxt;
                end_next = end_calc;
            end
            if (uw.ld_free)
            begin
                nxt_next = sum_nxt;
                prv_next = pos_reg - ffaa_pkg::POS_W'(prev_rd);
            end
            if (uw.adv)
            begin
                pos_next = nxt_reg[ffaa_pkg::POS_W-1:0];
            end

            if (uw.fin != ffaa_pkg::FIN_NONE)
            begin
                // hold the step until the output register can take the beat
                if (slot_free)
                begin
                    busy_next      = 1'b0;
                    out_valid_next = 1'b1;
                    if (uw.fin == ffaa_pkg::FIN_OK)
                    begin
                        out_status_next = ffaa_pkg::ST_OK;
                        out_offset_next = ffaa_pkg::WORD_W'(end_reg
                                        + ffaa_pkg::wide_t'(ffaa_pkg::HDR_WORDS));
                    end
                    else if (uw.fin == ffaa_pkg::FIN_FAIL)
                    begin
                        out_status_next = ffaa_pkg::ST_NO_SPACE;
                        out_offset_next = '0;
                    end
                    else
                    begin
                        out_status_next = ffaa_pkg::ST_OK;
                        out_offset_next = '0;
                    end
                end
            end
            else if (cond_true)
            begin
                step_next = uw.target;
            end
            else
            begin
                step_next = ffaa_pkg::step_t'(step_reg + 4'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            step_reg       <= ffaa_pkg::S_A0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            step_reg       <= step_next;
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_offset_reg <= out_offset_next;
        pos_reg        <= pos_next;
        prv_reg        <= prv_next;
        nxt_reg        <= nxt_next;
        end_reg        <= end_next;
        req_reg        <= req_next;
        req3_reg       <= req3_next;
        hlow_reg       <= hlow_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.payload_offset = out_offset_reg;

    ap_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg && !clr_active_reg)
        else $error("accepted beat did not start the sequencer");

    ap_fail_has_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == ffaa_pkg::ST_NO_SPACE) |-> rsp.payload_offset == '0)
        else $error("no-space result carries an offset");

    ap_new_header_in_arena: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && (uw.wr_sel == ffaa_pkg::WR_NEW)
        |-> (end_reg < ffaa_pkg::wide_t'(ffaa_pkg::ARENA_WORDS))
         && (ffaa_pkg::wide_t'(nxt_reg) > end_reg))
        else $error("new header written outside its gap");

    ap_clear_sweeps_all: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clr_active_reg) |-> $past(clr_addr_reg) == LAST_ADDR)
        else $error("clearing pass ended early");

endmodule

// ----- sv/ffaa_ram.sv -----
module ffaa_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 10
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- tb/testbench.sv -----
class arena_scoreboard;
    typedef struct packed {
        logic            status;
        ffaa_pkg::word_t offset;
    } reply_t;

    ffaa_pkg::word_t block_len [ffaa_pkg::ARENA_WORDS];
    ffaa_pkg::word_t fwd_jump [ffaa_pkg::ARENA_WORDS];
    ffaa_pkg::word_t back_jump [ffaa_pkg::ARENA_WORDS];
    reply_t          owed_replies [$];
    int              mismatches;
    int              compared;
    int              grants;
    int              refusals;
    int              releases;

    function new();
        foreach (block_len[i])
        begin
            block_len[i] = '0;
            fwd_jump[i]  = '0;
            back_jump[i] = '0;
        end
        fwd_jump[0]                  = ffaa_pkg::word_t'(ffaa_pkg::END_POS);
        back_jump[ffaa_pkg::END_POS] = ffaa_pkg::word_t'(ffaa_pkg::END_POS);
        mismatches = 0;
        compared   = 0;
        grants     = 0;
        refusals   = 0;
        releases   = 0;
    endfunction

    // first fit: walk the chain from the anchor, carve the first big enough gap
    function bit place_block(input int unsigned want, output int unsigned offset);
        int unsigned at;
        int unsigned jump;
        int unsigned nxt;
        int unsigned tail;
        at     = 0;
        offset = 0;
        while (at < ffaa_pkg::END_POS)
        begin
            jump = fwd_jump[at];
            nxt  = at + jump;
            if (jump == 0 || nxt >= ffaa_pkg::ARENA_WORDS)
                return 1'b0;
            tail = at + ffaa_pkg::HDR_WORDS + block_len[at];
            if (nxt >= tail && nxt - tail >= want + ffaa_pkg::HDR_WORDS)
            begin
                block_len[tail] = ffaa_pkg::word_t'(want);
                fwd_jump[tail]  = ffaa_pkg::word_t'(nxt - tail);
                back_jump[tail] = ffaa_pkg::word_t'(tail - at);
                fwd_jump[at]    = ffaa_pkg::word_t'(tail - at);
                back_jump[nxt]  = ffaa_pkg::word_t'(nxt - tail);
                offset = tail + ffaa_pkg::HDR_WORDS;
                return 1'b1;
            end
            at = nxt;
        end
        return 1'b0;
    endfunction

    function void unlink_block(input int unsigned h);
        int unsigned at;
        int unsigned back;
        int unsigned fwd;
        int unsigned prv;
        int unsigned nxt;
        if (h < ffaa_pkg::HDR_WORDS)
            return;
        at = h - ffaa_pkg::HDR_WORDS;
        if (at >= ffaa_pkg::ARENA_WORDS)
            return;
        back = back_jump[at];
        fwd  = fwd_jump[at];
        if (back > at)
            return;
        prv = at - back;
        nxt = at + fwd;
        if (nxt >= ffaa_pkg::ARENA_WORDS)
            return;
        fwd_jump[prv]  = ffaa_pkg::word_t'(nxt - prv);
        back_jump[nxt] = ffaa_pkg::word_t'(nxt - prv);
    endfunction

    function void note_request(input logic f, input ffaa_pkg::word_t want,
                               input ffaa_pkg::word_t h,
                               output logic st, output ffaa_pkg::word_t off);
        int unsigned spot;
        reply_t      r;
        st  = ffaa_pkg::ST_OK;
        off = '0;
        if (f == ffaa_pkg::FUNC_ALLOC)
        begin
            if (place_block(want, spot))
            begin
                off = ffaa_pkg::word_t'(spot);
                grants++;
            end
            else
            begin
                st = ffaa_pkg::ST_NO_SPACE;
                refusals++;
            end
        end
        else
        begin
            unlink_block(h);
            releases++;
        end
        r.status = st;
        r.offset = off;
        owed_replies.push_back(r);
    endfunction

    function void check_result(input logic st, input ffaa_pkg::word_t off);
        reply_t want;
        compared++;
        if (owed_replies.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected reply status=%0b offset=%0d", $time, st, off);
            return;
        end
        want = owed_replies.pop_front();
        if (st !== want.status || off !== want.offset)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: reply %0d wrong: status exp %0b got %0b, offset exp %0d got %0d",
                         $time, compared, want.status, st, want.offset, off);
        end
    endfunction
endclass

module testbench;
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ffaa_req_if req_chan ();
    ffaa_rsp_if rsp_chan ();

    first_fit_arena_allocator_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_chan),
        .rsp   (rsp_chan)
    );

    arena_scoreboard board;
    ffaa_pkg::word_t live_blocks [$];
    ffaa_pkg::word_t retired_blocks [$];

    always #6 clk = ~clk;

    initial
    begin
        #150_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 8);
    endfunction

    task automatic send_op(input logic f, input ffaa_pkg::word_t w, input ffaa_pkg::word_t h);
        logic            st;
        ffaa_pkg::word_t off;
        int              i;
        req_chan.valid     <= 1'b1;
        req_chan.func      <= f;
        req_chan.req_words <= w;
        req_chan.handle    <= h;
        @(posedge clk);
        while (req_chan.ready !== 1'b1)
            @(posedge clk);
        board.note_request(f, w, h, st, off);
        if (f == ffaa_pkg::FUNC_ALLOC)
        begin
            if (st == ffaa_pkg::ST_OK)
                live_blocks.push_back(off);
        end
        else
        begin
            for (i = 0; i < live_blocks.size(); i++)
            begin
                if (live_blocks[i] == h)
                begin
                    live_blocks.delete(i);
                    retired_blocks.push_back(h);
                    if (retired_blocks.size() > 16)
                        void'(retired_blocks.pop_front());
                    break;
                end
            end
        end
    endtask

    task automatic hold_off(input int unsigned n);
        if (n > 0)
        begin
            req_chan.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic settle_replies();
        req_chan.valid <= 1'b0;
        @(posedge clk);
        while (board.owed_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic alloc_op(input ffaa_pkg::word_t w);
        send_op(ffaa_pkg::FUNC_ALLOC, w, '0);
        hold_off(pick_gap());
    endtask

    task automatic free_op(input ffaa_pkg::word_t h);
        send_op(ffaa_pkg::FUNC_FREE, '0, h);
        hold_off(pick_gap());
    endtask

    initial
    begin
        int unsigned stall;
        int unsigned cyc;
        stall = 0;
        cyc   = 0;
        rsp_chan.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (rst_n && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
                board.check_result(rsp_chan.status, rsp_chan.payload_offset);
            if (stall > 0)
            begin
                stall--;
                rsp_chan.ready <= 1'b0;
            end
            else if ((cyc % 3000) >= 500 && $urandom_range(7) == 0)
            begin
                stall = pick_gap();
                rsp_chan.ready <= (stall == 0);
            end
            else
                rsp_chan.ready <= 1'b1;
        end
    end

    initial
    begin
        int          i;
        int unsigned roll;
        int unsigned sz;
        int unsigned failures;
        board = new();
        req_chan.valid     <= 1'b0;
        req_chan.func      <= ffaa_pkg::FUNC_ALLOC;
        req_chan.req_words <= '0;
        req_chan.handle    <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // largest fit, then one word too many, then 1021 words
        alloc_op(10'd1015);
        free_op(10'd6);
        alloc_op(10'd1016);
        alloc_op(10'd1021);
        alloc_op(10'd0);
        // handles below the header, the anchor, and a never-used top position
        free_op(10'd0);
        free_op(10'd1);
        free_op(10'd2);
        free_op(10'd3);
        free_op(10'd1023);
        free_op(10'd6);
        // stale double free relinks into a larger block: neighbour overlaps its payload
        alloc_op(10'd0);
        alloc_op(10'd50);
        alloc_op(10'd0);
        free_op(10'd9);
        free_op(10'd6);
        free_op(10'd62);
        alloc_op(10'd100);
        free_op(10'd9);
        alloc_op(10'd0);
        settle_replies();

        for (i = 0; i < 2000; i++)
        begin
            if (i % 500 == 250)
                settle_replies();
            roll = $urandom_range(99);
            if (roll < 50 || (roll < 85 && live_blocks.size() == 0))
            begin
                sz = $urandom_range(99);
                if (sz < 80)
                    send_op(ffaa_pkg::FUNC_ALLOC, ffaa_pkg::word_t'($urandom_range(24)), '0);
                else if (sz < 95)
                    send_op(ffaa_pkg::FUNC_ALLOC,
                            ffaa_pkg::word_t'($urandom_range(200, 25)), '0);
                else
                    send_op(ffaa_pkg::FUNC_ALLOC,
                            ffaa_pkg::word_t'($urandom_range(1021)), '0);
            end
            else if (roll < 85)
                send_op(ffaa_pkg::FUNC_FREE, ffaa_pkg::word_t'($urandom()),
                        live_blocks[$urandom_range(live_blocks.size() - 1)]);
            else if (roll < 92 && retired_blocks.size() != 0)
                send_op(ffaa_pkg::FUNC_FREE, '0,
                        retired_blocks[$urandom_range(retired_blocks.size() - 1)]);
            else
                send_op(ffaa_pkg::FUNC_FREE, '0, ffaa_pkg::word_t'($urandom_range(1023)));
            if ((i % 400) >= 80)
                hold_off(pick_gap());
        end

        settle_replies();
        repeat (40) @(posedge clk);
        failures = board.mismatches + board.owed_replies.size();
        $display("Covered %0d allocations granted, %0d refused for lack of space, %0d frees",
                 board.grants, board.refusals, board.releases);
        $display("Compared %0d replies, %0d wrong or unexpected", board.compared,
                 board.mismatches);
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
